// File: sv/tfdc_pkg.sv
`default_nettype none

package tfdc_pkg;

  localparam int unsigned WordW       = 16;
  localparam int unsigned LenW        = 14;
  localparam int unsigned MaxDataWords = 2048;
  localparam int unsigned CountW      = $clog2(MaxDataWords);
  localparam int unsigned IndexW      = 11;
  localparam int unsigned KindW       = 3;

  typedef enum logic [KindW-1:0] {
    KIND_DATA    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_NOLEN   = 3'd3,
    KIND_BADFLAG = 3'd4,
    KIND_RANGE   = 3'd5
  } kind_e;

  localparam logic [1:0] FLAGS_CSUM = 2'b00;
  localparam logic [1:0] FLAGS_NOCS = 2'b01;
  localparam logic [1:0] FLAGS_BAD  = 2'b10;
  localparam logic [1:0] FLAGS_NOLEN = 2'b11;

  // Decoded header word.
  typedef struct packed {
    logic              err;
    kind_e             err_kind;
    logic              has_csum;
    logic [CountW-1:0] count;
  } hdr_t;

endpackage

`default_nettype wire

// File: sv/tfdc_in_if.sv
`default_nettype none

interface tfdc_in_if;
  import tfdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);
endinterface

`default_nettype wire

// File: sv/tfdc_out_if.sv
`default_nettype none

interface tfdc_out_if;
  import tfdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [7:0]        tag_mode;
  logic [7:0]        tag_submode;
  logic [WordW-1:0]  data_word;
  logic [IndexW-1:0] word_index;
  logic              last;

  modport source (output valid, output kind, output tag_mode, output tag_submode,
                  output data_word, output word_index, output last, input ready);
  modport sink   (input valid, input kind, input tag_mode, input tag_submode,
                  input data_word, input word_index, input last, output ready);
endinterface

`default_nettype wire

// File: sv/tfdc_hdr_dec.sv
`default_nettype none

module tfdc_hdr_dec
  import tfdc_pkg::*;
(
  input  wire logic [WordW-1:0] word_i,
  output hdr_t                  hdr_o
);

  logic [1:0]    flags;
  logic [LenW-1:0] len;
  logic [LenW:0] diff;
  logic [LenW:0] overhead;

  assign flags    = word_i[WordW-1 -: 2];
  assign len      = word_i[LenW-1:0];
  assign overhead = (flags == FLAGS_CSUM) ? (LenW+1)'(3) : (LenW+1)'(2);
  // Borrow out of the subtract flags a length shorter than the overhead.
  assign diff     = {1'b0, len} - overhead;

  always_comb begin
    hdr_o.err      = 1'b0;
    hdr_o.err_kind = KIND_RANGE;
    hdr_o.has_csum = (flags == FLAGS_CSUM);
    hdr_o.count    = diff[CountW-1:0];
    case (flags)
      FLAGS_NOLEN: begin
        hdr_o.err      = 1'b1;
        hdr_o.err_kind = KIND_NOLEN;
      end
      FLAGS_BAD: begin
        hdr_o.err      = 1'b1;
        hdr_o.err_kind = KIND_BADFLAG;
      end
      FLAGS_CSUM, FLAGS_NOCS: begin
        if (diff[LenW] || (diff[LenW-1:0] > LenW'(MaxDataWords - 1))) begin
          hdr_o.err      = 1'b1;
          hdr_o.err_kind = KIND_RANGE;
        end
      end
      default: begin
        hdr_o.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/tagged_field_deframer_checksum_unit.sv
`default_nettype none
// Results: a word is held in the input register, and its result then goes to the result
//   register; header and tag words that give no result just update state.
// Throughput: one word per cycle, sustained while the result side takes results.
// Reset: rst_ni low clears both stages and the field state; the block then
//   waits for a header word.

module tagged_field_deframer_checksum_unit
  import tfdc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tfdc_in_if.sink     in_i,
  tfdc_out_if.source  out_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TAG    = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_CSUM   = 2'd3;

  logic             in_valid_q;
  logic [WordW-1:0] in_word_q;
  logic             fire;

  logic [1:0]        phase_q, phase_d;
  logic              has_csum_q, has_csum_d;
  logic [CountW-1:0] left_q, left_d;
  logic [WordW-1:0]  sum_q, sum_d;
  logic [WordW-1:0]  tag_q, tag_d;
  logic [IndexW-1:0] index_q, index_d;

  logic              res_valid;
  kind_e             res_kind;
  logic [WordW-1:0]  res_tag;
  logic [WordW-1:0]  res_data;
  logic [IndexW-1:0] res_index;
  logic              res_last;

  logic              out_valid_q;
  logic [KindW-1:0]  out_kind_q;
  logic [WordW-1:0]  out_tag_q;
  logic [WordW-1:0]  out_data_q;
  logic [IndexW-1:0] out_index_q;
  logic              out_last_q;

  hdr_t hdr;

  tfdc_hdr_dec u_hdr_dec (
    .word_i (in_word_q),
    .hdr_o  (hdr)
  );

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q <= in_i.word_in;
    end
  end

  always_comb begin
    logic [WordW-1:0]  sum_add;
    logic [CountW-1:0] left_dec;
    sum_add    = sum_q + in_word_q;
    left_dec   = (left_q == '0) ? '0 : left_q - CountW'(1);
    phase_d    = phase_q;
    has_csum_d = has_csum_q;
    left_d     = left_q;
    sum_d      = sum_q;
    tag_d      = tag_q;
    index_d    = index_q;
    res_valid  = 1'b0;
    res_kind   = KIND_DONE;
    res_tag    = tag_q;
    res_data   = '0;
    res_index  = '0;
    res_last   = 1'b1;
    case (phase_q)
      PH_HEADER: begin
        if (hdr.err) begin
          res_valid = 1'b1;
          res_kind  = hdr.err_kind;
          res_tag   = '0;
        end else begin
          has_csum_d = hdr.has_csum;
          left_d     = hdr.count;
          sum_d      = hdr.has_csum ? in_word_q : '0;
          index_d    = '0;
          phase_d    = PH_TAG;
        end
      end
      PH_TAG: begin
        tag_d = in_word_q;
        if (has_csum_q) begin
          sum_d = sum_add;
        end
        if (left_q != '0) begin
          phase_d = PH_DATA;
        end else if (has_csum_q) begin
          phase_d = PH_CSUM;
        end else begin
          phase_d   = PH_HEADER;
          res_valid = 1'b1;
          res_tag   = in_word_q;
        end
      end
      PH_DATA: begin
        if (has_csum_q) begin
          sum_d = sum_add;
        end
        index_d   = index_q + IndexW'(1);
        left_d    = left_dec;
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = in_word_q;
        res_index = index_q;
        res_last  = 1'b0;
        if (left_dec == '0) begin
          if (has_csum_q) begin
            phase_d = PH_CSUM;
          end else begin
            phase_d  = PH_HEADER;
            res_last = 1'b1;
          end
        end
      end
      PH_CSUM: begin
        sum_d     = sum_add;
        phase_d   = PH_HEADER;
        res_valid = 1'b1;
        res_kind  = (sum_add == '0) ? KIND_DONE : KIND_BADSUM;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  // Advance field state only when the word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      has_csum_q <= 1'b0;
      left_q     <= '0;
      sum_q      <= '0;
      tag_q      <= '0;
      index_q    <= '0;
    end else if (fire) begin
      phase_q    <= phase_d;
      has_csum_q <= has_csum_d;
      left_q     <= left_d;
      sum_q      <= sum_d;
      tag_q      <= tag_d;
      index_q    <= index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_tag_q   <= res_tag;
      out_data_q  <= res_data;
      out_index_q <= res_index;
      out_last_q  <= res_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.tag_mode    = out_tag_q[15:8];
  assign out_o.tag_submode = out_tag_q[7:0];
  assign out_o.data_word   = out_data_q;
  assign out_o.word_index  = out_index_q;
  assign out_o.last        = out_last_q;

endmodule

`default_nettype wire

// File: sv/tfdc_checker.sv
`default_nettype none

module tfdc_checker
  import tfdc_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [KindW-1:0]  kind_i,
  input wire logic [7:0]        tag_mode_i,
  input wire logic [7:0]        tag_submode_i,
  input wire logic [WordW-1:0]  data_word_i,
  input wire logic [IndexW-1:0] word_index_i,
  input wire logic              last_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(data_word_i)
      && $stable(word_index_i) && $stable(last_i))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_DATA) |-> last_i && (data_word_i == '0)
      && (word_index_i == '0))
    else $error("status result without last or with data");

  a_hdr_err_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((kind_i == KIND_NOLEN) || (kind_i == KIND_BADFLAG)
      || (kind_i == KIND_RANGE)) |-> (tag_mode_i == '0) && (tag_submode_i == '0))
    else $error("header error carries a tag");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind tagged_field_deframer_checksum_unit tfdc_checker u_tfdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .tag_mode_i    (out_o.tag_mode),
  .tag_submode_i (out_o.tag_submode),
  .data_word_i   (out_o.data_word),
  .word_index_i  (out_o.word_index),
  .last_i        (out_o.last)
);

`default_nettype wire
